FILE: hw/rtl/arfp_pkg.sv
// Shared types and character constants for the ASCII request frame parser.
// Used by the interfaces, the front and back modules and the top level.
// No dependencies.
package arfp_pkg;

    localparam int CFG_IDX_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STATION_ADDRESS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGISTER_COUNT  = 8'd1;

    // Characters with a meaning of their own.
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_SPACE = 8'd32;

    // Function codes accepted in a request.
    localparam logic [7:0] FUNC_READ  = 8'd3;
    localparam logic [7:0] FUNC_WRITE = 8'd6;

    // Result kinds and exception codes.
    localparam logic       KIND_FRAME     = 1'b0;
    localparam logic       KIND_EXCEPTION = 1'b1;
    localparam logic [1:0] EXC_ILLEGAL_FUNCTION = 2'd0;
    localparam logic [1:0] EXC_ILLEGAL_ADDRESS  = 2'd1;
    localparam logic [1:0] EXC_ILLEGAL_VALUE    = 2'd2;

    // Class of one received character after the front end.
    typedef enum logic [2:0] {
        TOK_COLON,
        TOK_HEX,
        TOK_CR,
        TOK_LF,
        TOK_OTHER
    } tok_kind_t;

    // Nibble is 15 for every character that is not an upper-case hex digit.
    typedef struct packed {
        tok_kind_t  kind;
        logic [3:0] nibble;
    } token_t;

    typedef struct packed {
        logic [7:0] station_address;
        logic [7:0] register_count;
    } cfg_t;

endpackage

FILE: hw/rtl/arfp_if.sv
// Channel interfaces of the ASCII request frame parser: received characters,
// results and configuration writes. Depends on arfp_pkg.
interface arfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface arfp_res_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [1:0]  exception_code;
    logic [7:0]  function_code;
    logic [7:0]  register_address;
    logic [15:0] data_value;

    modport source (output valid, output result_kind, output exception_code,
                    output function_code, output register_address,
                    output data_value, input ready);
    modport sink   (input valid, input result_kind, input exception_code,
                    input function_code, input register_address,
                    input data_value, output ready);
endinterface

interface arfp_cfg_if
    import arfp_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/arfp_front.sv
// Front end: classifies each received character into a token and drops
// tabs and spaces. Depends on arfp_pkg and arfp_if.
module arfp_front
    import arfp_pkg::*;
(
    arfp_rx_if.sink rx,
    output logic    tok_valid,
    output token_t  tok,
    input  logic    tok_ready
);

    logic skip;

    assign skip      = (rx.rx_byte == CHAR_TAB) || (rx.rx_byte == CHAR_SPACE);
    assign tok_valid = rx.valid && !skip;
    assign rx.ready  = tok_ready;

    always_comb
    begin
        tok.nibble = 4'hF;
        if (rx.rx_byte >= 8'h30 && rx.rx_byte <= 8'h39)
        begin
            tok.kind   = TOK_HEX;
            tok.nibble = 4'(rx.rx_byte - 8'h30);
        end
        else if (rx.rx_byte >= 8'h41 && rx.rx_byte <= 8'h46)
        begin
            tok.kind   = TOK_HEX;
            tok.nibble = 4'(rx.rx_byte - 8'h37);
        end
        else if (rx.rx_byte == CHAR_COLON)
        begin
            tok.kind = TOK_COLON;
        end
        else if (rx.rx_byte == CHAR_CR)
        begin
            tok.kind = TOK_CR;
        end
        else if (rx.rx_byte == CHAR_LF)
        begin
            tok.kind = TOK_LF;
        end
        else
        begin
            tok.kind = TOK_OTHER;
        end
    end

endmodule

FILE: hw/rtl/arfp_queue.sv
// Short token queue between the front end and the frame parser.
// Depends on arfp_pkg.
module arfp_queue
    import arfp_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  token_t in_tok,
    output logic   out_valid,
    input  logic   out_ready,
    output token_t out_tok
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    token_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_tok   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_tok;
        end
    end

endmodule

FILE: hw/rtl/arfp_back.sv
// Frame parser: walks the tokens through the frame fields, checks station,
// function, address, LRC and the closing CR and LF, and holds each result in
// an output register. Depends on arfp_pkg and arfp_if.
module arfp_back
    import arfp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  cfg_t           cfg,
    input  logic           tok_valid,
    output logic           tok_ready,
    input  token_t         tok,
    arfp_res_if.source     res
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_STN,
        PH_FUNC,
        PH_ADRH,
        PH_ADRL,
        PH_VALH,
        PH_VALL,
        PH_LRC,
        PH_CR,
        PH_LF
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        high_reg, high_next;
    logic [3:0]  held_reg, held_next;
    logic [7:0]  func_reg, func_next;
    logic [7:0]  addr_reg, addr_next;
    logic [15:0] value_reg, value_next;
    logic [7:0]  lrc_reg, lrc_next;

    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [1:0]  out_code_reg;
    logic [7:0]  out_func_reg;
    logic [7:0]  out_addr_reg;
    logic [15:0] out_value_reg;

    logic        take;
    logic        emit;
    logic        emit_kind;
    logic [1:0]  emit_code;
    logic [7:0]  byte_val;

    assign tok_ready = !out_valid_reg || res.ready;
    assign take      = tok_valid && tok_ready;
    // A non-hex character in the low position forces the whole byte to all ones.
    assign byte_val  = (tok.kind == TOK_HEX) ? {held_reg, tok.nibble} : 8'hFF;

    always_comb
    begin
        phase_next = phase_reg;
        high_next  = high_reg;
        held_next  = held_reg;
        func_next  = func_reg;
        addr_next  = addr_reg;
        value_next = value_reg;
        lrc_next   = lrc_reg;
        emit       = 1'b0;
        emit_kind  = KIND_EXCEPTION;
        emit_code  = EXC_ILLEGAL_VALUE;
        if (tok.kind == TOK_COLON)
        begin
            phase_next = PH_STN;
            high_next  = 1'b1;
            func_next  = '0;
            addr_next  = '0;
            value_next = '0;
            lrc_next   = '0;
        end
        else if (phase_reg == PH_CR)
        begin
            if (tok.kind == TOK_CR)
            begin
                phase_next = PH_LF;
            end
            else
            begin
                emit = 1'b1;
            end
        end
        else if (phase_reg == PH_LF)
        begin
            emit = 1'b1;
            if (tok.kind == TOK_LF)
            begin
                emit_kind = KIND_FRAME;
                emit_code = '0;
            end
        end
        else if (phase_reg == PH_IDLE || phase_reg > PH_LRC)
        begin
            phase_next = PH_IDLE;
        end
        else if (high_reg)
        begin
            high_next = 1'b0;
            held_next = tok.nibble;
        end
        else
        begin
            high_next = 1'b1;
            lrc_next  = lrc_reg + byte_val;
            unique case (phase_reg)
                PH_STN:
                begin
                    phase_next = (byte_val == cfg.station_address) ? PH_FUNC : PH_IDLE;
                end
                PH_FUNC:
                begin
                    func_next = byte_val;
                    if (byte_val == FUNC_READ || byte_val == FUNC_WRITE)
                    begin
                        phase_next = PH_ADRH;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        emit_code = EXC_ILLEGAL_FUNCTION;
                    end
                end
                PH_ADRH:
                begin
                    if (byte_val != 8'h00)
                    begin
                        emit      = 1'b1;
                        emit_code = EXC_ILLEGAL_ADDRESS;
                    end
                    else
                    begin
                        phase_next = PH_ADRL;
                    end
                end
                PH_ADRL:
                begin
                    addr_next = byte_val;
                    if (byte_val >= cfg.register_count)
                    begin
                        emit      = 1'b1;
                        emit_code = EXC_ILLEGAL_ADDRESS;
                    end
                    else
                    begin
                        phase_next = PH_VALH;
                    end
                end
                PH_VALH:
                begin
                    value_next = {byte_val, 8'h00};
                    phase_next = PH_VALL;
                end
                PH_VALL:
                begin
                    value_next = {value_reg[15:8], byte_val};
                    phase_next = PH_LRC;
                end
                default:
                begin
                    // The LRC byte must be the two's complement of the byte sum.
                    lrc_next = lrc_reg;
                    if (8'(~lrc_reg + 8'd1) != byte_val)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_CR;
                    end
                end
            endcase
        end
        if (emit)
        begin
            phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            high_reg      <= 1'b1;
            held_reg      <= '0;
            func_reg      <= '0;
            addr_reg      <= '0;
            value_reg     <= '0;
            lrc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_next;
                high_reg  <= high_next;
                held_reg  <= held_next;
                func_reg  <= func_next;
                addr_reg  <= addr_next;
                value_reg <= value_next;
                lrc_reg   <= lrc_next;
            end
            if (tok_ready)
            begin
                out_valid_reg <= take && emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_kind_reg  <= emit_kind;
            out_code_reg  <= emit_code;
            out_func_reg  <= func_next;
            out_addr_reg  <= addr_next;
            out_value_reg <= value_next;
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.result_kind      = out_kind_reg;
    assign res.exception_code   = out_code_reg;
    assign res.function_code    = out_func_reg;
    assign res.register_address = out_addr_reg;
    assign res.data_value       = out_value_reg;

endmodule

FILE: hw/rtl/ascii_request_frame_parser_unit.sv
// Top level of the ASCII request frame parser: configuration registers,
// front end, token queue and frame parser. Depends on arfp_pkg and arfp_if.
//
// Usage: the rx channel carries one received character per transfer. A colon
// starts a frame, tabs and spaces are dropped, and hex pairs are decoded into
// station, function, address, value and LRC bytes followed by CR and LF.
// The res channel carries one result per completed frame (at its LF) or per
// detected error; frames addressed to another station give no result.
// The cfg channel writes station_address (index 0) and register_count
// (index 1); other indexes are ignored. It is always ready and should only
// be used while no frame is in flight.
// Throughput: one character per cycle, sustained while the result receiver
// does not stall. A result reaches res by way of the token queue stage and
// then the output register after the transfer of the character that causes it.
// If the result receiver stalls, the parser holds, the token queue of
// QUEUE_DEPTH entries fills and then rx ready drops.
// Reset clears the parser to wait for a colon, empties the queue and the
// output register, and loads station 1 and register count 5.
module ascii_request_frame_parser_unit
    import arfp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    arfp_rx_if.sink    rx,
    arfp_res_if.source res,
    arfp_cfg_if.sink   cfg
);

    cfg_t   cfg_reg;
    logic   front_valid, front_ready;
    token_t front_tok;
    logic   back_valid, back_ready;
    token_t back_tok;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.station_address <= 8'd1;
            cfg_reg.register_count  <= 8'd5;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_STATION_ADDRESS)
            begin
                cfg_reg.station_address <= cfg.data;
            end
            else if (cfg.index == CFG_REGISTER_COUNT)
            begin
                cfg_reg.register_count <= cfg.data;
            end
        end
    end

    arfp_front u_front (
        .rx        (rx),
        .tok_valid (front_valid),
        .tok       (front_tok),
        .tok_ready (front_ready)
    );

    arfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_tok    (front_tok),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_tok   (back_tok)
    );

    arfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .tok_valid (back_valid),
        .tok_ready (back_ready),
        .tok       (back_tok),
        .res       (res)
    );

endmodule

FILE: hw/rtl/arfp_checker.sv
// Port-level checks on the results of the ASCII request frame parser, and
// the bind that attaches them to the top level. Depends on arfp_pkg.
module arfp_checker
    import arfp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        result_kind,
    input logic [1:0]  exception_code,
    input logic [7:0]  function_code,
    input logic [7:0]  register_address,
    input logic [15:0] data_value
);

    // A completed frame always carries a supported function and no code.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result_kind == KIND_FRAME |->
            exception_code == '0 &&
            (function_code == FUNC_READ || function_code == FUNC_WRITE))
        else $error("frame result with bad function or nonzero code");

    // An illegal function stops decoding before address and value.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result_kind == KIND_EXCEPTION &&
        exception_code == EXC_ILLEGAL_FUNCTION |->
            function_code != FUNC_READ && function_code != FUNC_WRITE &&
            register_address == '0 && data_value == '0)
        else $error("illegal function exception with decoded fields");

    // Only three exception codes exist.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> exception_code != 2'd3)
        else $error("undefined exception code");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=>
            res_valid && $stable(result_kind) && $stable(exception_code) &&
            $stable(function_code) && $stable(register_address) &&
            $stable(data_value))
        else $error("stalled result changed");

endmodule

bind ascii_request_frame_parser_unit arfp_checker u_arfp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .result_kind      (res.result_kind),
    .exception_code   (res.exception_code),
    .function_code    (res.function_code),
    .register_address (res.register_address),
    .data_value       (res.data_value)
);

FILE: tb/sv/testbench.sv
// Self-checking testbench of ascii_request_frame_parser_unit: a directed table of
// frames, then randomized frames and line noise under several register settings.
// Depends on arfp_pkg and the channel interfaces of arfp_if.
module testbench;
    import arfp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_ROWS     = 16;
    localparam int NUM_SETTINGS = 6;
    localparam int PHASE_CHARS  = 95;
    localparam int PHASE_FRAMES = 4;

    // The exception code field reads zero in a good frame.
    localparam logic [1:0] NO_EXCEPTION = 2'd0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STATION,
        S_FUNCTION,
        S_ADDR_HI,
        S_ADDR_LO,
        S_VALUE_HI,
        S_VALUE_LO,
        S_LRC,
        S_CR,
        S_LF
    } parse_phase_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  code;
        logic [7:0]  fn;
        logic [7:0]  addr;
        logic [15:0] value;
    } frame_result_t;

    // A row with typed set carries its result written out by hand; the
    // other rows are left to the frame decoder below.
    typedef struct packed {
        logic          typed;
        frame_result_t outcome;
    } row_check_t;

    localparam row_check_t BY_DECODER = '0;

    logic clk;
    logic rst_n;
    int   cycle_count = 0;
    int   mismatches  = 0;
    int   chars_sent  = 0;
    int   frames_announced = 0;
    bit   steady = 1'b0;

    arfp_rx_if  rx ();
    arfp_res_if res ();
    arfp_cfg_if cfg ();

    ascii_request_frame_parser_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .res   (res),
        .cfg   (cfg)
    );

    // Registers and parser state as the block should hold them.
    logic [7:0]   own_station = 8'd1;
    logic [7:0]   reg_count   = 8'd5;
    parse_phase_t phase       = S_IDLE;
    logic         high_next   = 1'b1;
    logic [7:0]   held        = '0;
    logic [7:0]   frame_fn    = '0;
    logic [7:0]   frame_addr  = '0;
    logic [15:0]  frame_value = '0;
    logic [7:0]   lrc_sum     = '0;

    frame_result_t frames_due [$];
    row_check_t    row_check_now = '0;

    string directed_chars [NUM_ROWS] = '{
        ":010300020001F9\r\n",
        ":01060004FFFFF7\r\n",
        ":0110",
        ":\t01 0G",
        ":010301",
        ":01030005",
        ":01030000000AF3\r\n",
        ":01030000000AF2X",
        ":01030000000AF2\r\r",
        ":020300000001FA\r\n",
        ":0103:01030001000AF1\r\n",
        "Z\r\n01",
        ":01030000000aF2\r\n",
        ":G1060000",
        ": 0 1 0 6 0 0 0 3 1 2 A B 3 9\r\n",
        ":01030000000AF2:0103"
    };

    row_check_t directed_checks [NUM_ROWS] = '{
        '{1'b1, '{KIND_FRAME, NO_EXCEPTION, FUNC_READ, 8'h02, 16'h0001}},
        '{1'b1, '{KIND_FRAME, NO_EXCEPTION, FUNC_WRITE, 8'h04, 16'hFFFF}},
        '{1'b1, '{KIND_EXCEPTION, EXC_ILLEGAL_FUNCTION, 8'h10, 8'h00, 16'h0000}},
        // A non-hex low digit turns the whole function byte into all ones.
        '{1'b1, '{KIND_EXCEPTION, EXC_ILLEGAL_FUNCTION, 8'hFF, 8'h00, 16'h0000}},
        '{1'b1, '{KIND_EXCEPTION, EXC_ILLEGAL_ADDRESS, FUNC_READ, 8'h00, 16'h0000}},
        '{1'b1, '{KIND_EXCEPTION, EXC_ILLEGAL_ADDRESS, FUNC_READ, 8'h05, 16'h0000}},
        '{1'b1, '{KIND_EXCEPTION, EXC_ILLEGAL_VALUE, FUNC_READ, 8'h00, 16'h000A}},
        '{1'b1, '{KIND_EXCEPTION, EXC_ILLEGAL_VALUE, FUNC_READ, 8'h00, 16'h000A}},
        '{1'b1, '{KIND_EXCEPTION, EXC_ILLEGAL_VALUE, FUNC_READ, 8'h00, 16'h000A}},
        BY_DECODER,
        BY_DECODER,
        BY_DECODER,
        BY_DECODER,
        BY_DECODER,
        BY_DECODER,
        BY_DECODER
    };

    function automatic logic [7:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return c - "0";
        if (c >= "A" && c <= "F")
            return c - "A" + 8'd10;
        return 8'hFF;
    endfunction

    function automatic frame_result_t close_frame(input logic kind, input logic [1:0] code);
        phase = S_IDLE;
        return '{kind, code, frame_fn, frame_addr, frame_value};
    endfunction

    // Advances the parser by one character; returns 1 when it yields a result.
    function automatic bit decode_char(input logic [7:0] c, output frame_result_t r);
        logic [7:0] b;
        r = '0;
        if (c == CHAR_COLON) begin
            phase       = S_STATION;
            high_next   = 1'b1;
            frame_fn    = '0;
            frame_addr  = '0;
            frame_value = '0;
            lrc_sum     = '0;
            return 1'b0;
        end
        if (c == CHAR_TAB || c == CHAR_SPACE)
            return 1'b0;
        if (phase == S_CR) begin
            if (c == CHAR_CR) begin
                phase = S_LF;
                return 1'b0;
            end
            r = close_frame(KIND_EXCEPTION, EXC_ILLEGAL_VALUE);
            return 1'b1;
        end
        if (phase == S_LF) begin
            if (c == CHAR_LF)
                r = close_frame(KIND_FRAME, NO_EXCEPTION);
            else
                r = close_frame(KIND_EXCEPTION, EXC_ILLEGAL_VALUE);
            return 1'b1;
        end
        if (phase == S_IDLE)
            return 1'b0;
        if (high_next) begin
            high_next = 1'b0;
            held      = hex_digit(c);
            return 1'b0;
        end
        high_next = 1'b1;
        b = {held[3:0], 4'h0} | hex_digit(c);
        if (phase != S_LRC)
            lrc_sum = lrc_sum + b;
        case (phase)
            S_STATION:
                phase = (b == own_station) ? S_FUNCTION : S_IDLE;
            S_FUNCTION:
            begin
                frame_fn = b;
                if (b != FUNC_READ && b != FUNC_WRITE) begin
                    r = close_frame(KIND_EXCEPTION, EXC_ILLEGAL_FUNCTION);
                    return 1'b1;
                end
                phase = S_ADDR_HI;
            end
            S_ADDR_HI:
            begin
                if (b != 8'h00) begin
                    r = close_frame(KIND_EXCEPTION, EXC_ILLEGAL_ADDRESS);
                    return 1'b1;
                end
                phase = S_ADDR_LO;
            end
            S_ADDR_LO:
            begin
                frame_addr = b;
                if (b >= reg_count) begin
                    r = close_frame(KIND_EXCEPTION, EXC_ILLEGAL_ADDRESS);
                    return 1'b1;
                end
                phase = S_VALUE_HI;
            end
            S_VALUE_HI:
            begin
                frame_value = {b, 8'h00};
                phase       = S_VALUE_LO;
            end
            S_VALUE_LO:
            begin
                frame_value[7:0] = b;
                phase            = S_LRC;
            end
            default:
            begin
                if (8'h00 - lrc_sum != b) begin
                    r = close_frame(KIND_EXCEPTION, EXC_ILLEGAL_VALUE);
                    return 1'b1;
                end
                phase = S_CR;
            end
        endcase
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] seen,
                                   input logic [15:0] wanted);
        mismatches++;
        if (mismatches <= 50)
            $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, seen, wanted);
    endtask

    task automatic send_char(input logic [7:0] c);
        frame_result_t predicted;
        if (!steady && $urandom_range(0, 5) == 0) begin
            rx.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= c;
        do @(posedge clk); while (!rx.ready);
        chars_sent++;
        if (decode_char(c, predicted)) begin
            frames_due.push_back(row_check_now.typed ? row_check_now.outcome : predicted);
            frames_announced++;
        end
    endtask

    // Occasionally puts a tab or a space in front of the character.
    task automatic send_loose(input logic [7:0] c);
        if ($urandom_range(0, 11) == 0)
            send_char(($urandom_range(0, 1) != 0) ? CHAR_TAB : CHAR_SPACE);
        send_char(c);
    endtask

    // Upper-case hex digit, now and then replaced by an arbitrary character.
    function automatic logic [7:0] noisy_hex(input logic [3:0] n);
        if ($urandom_range(0, 79) == 0)
            return 8'($urandom_range(0, 255));
        return (n < 4'd10) ? "0" + n : "A" + n - 8'd10;
    endfunction

    task automatic send_random_frame();
        logic [7:0] fields [7];
        logic [7:0] sum;
        int         byte_total;
        int         pick;
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 5)) send_char(8'($urandom_range(0, 255)));
        fields[0] = ($urandom_range(0, 6) != 0) ? own_station : 8'($urandom);
        pick = $urandom_range(0, 9);
        fields[1] = (pick < 4) ? FUNC_READ : (pick < 8) ? FUNC_WRITE : 8'($urandom);
        fields[2] = ($urandom_range(0, 9) != 0) ? 8'h00 : 8'($urandom);
        fields[3] = (reg_count != 8'd0 && $urandom_range(0, 4) != 0) ?
                    8'($urandom_range(0, reg_count - 1)) : 8'($urandom);
        pick = $urandom_range(0, 7);
        {fields[4], fields[5]} = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF :
                                 16'($urandom);
        sum = '0;
        for (int i = 0; i < 6; i++)
            sum = sum + fields[i];
        fields[6] = ($urandom_range(0, 7) != 0) ? 8'(-sum) : 8'($urandom);
        // Some frames break off early and are cut short by the next colon.
        byte_total = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 7;
        send_loose(CHAR_COLON);
        for (int i = 0; i < byte_total; i++) begin
            send_loose(noisy_hex(fields[i][7:4]));
            send_loose(noisy_hex(fields[i][3:0]));
        end
        if (byte_total == 7) begin
            send_loose(($urandom_range(0, 14) != 0) ? CHAR_CR : 8'($urandom));
            send_loose(($urandom_range(0, 14) != 0) ? CHAR_LF : 8'($urandom));
        end
    endtask

    task automatic settle();
        rx.valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes an unused index first, then both registers, keeping valid high.
    task automatic program_config(input logic [7:0] station, input logic [7:0] count,
                                  input logic [CFG_IDX_W-1:0] stray);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [7:0]           data [3];
        idx  = '{stray, CFG_STATION_ADDRESS, CFG_REGISTER_COUNT};
        data = '{8'($urandom), station, count};
        for (int i = 0; i < 3; i++) begin
            cfg.valid <= 1'b1;
            cfg.index <= idx[i];
            cfg.data  <= data[i];
            do @(posedge clk); while (!cfg.ready);
            if (idx[i] == CFG_STATION_ADDRESS)
                own_station = data[i];
            else if (idx[i] == CFG_REGISTER_COUNT)
                reg_count = data[i];
        end
        cfg.valid <= 1'b0;
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : result_ready
        res.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            if (!steady && $urandom_range(0, 4) == 0) begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            res.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk) begin : check_results
        frame_result_t want;
        if (rst_n && res.valid && res.ready) begin
            if (frames_due.size() == 0) begin
                report_mismatch("unexpected result", res.function_code, 16'h0000);
            end
            else begin
                want = frames_due.pop_front();
                if (res.result_kind !== want.kind)
                    report_mismatch("result_kind", res.result_kind, want.kind);
                if (res.exception_code !== want.code)
                    report_mismatch("exception_code", res.exception_code, want.code);
                if (res.function_code !== want.fn)
                    report_mismatch("function_code", res.function_code, want.fn);
                if (res.register_address !== want.addr)
                    report_mismatch("register_address", res.register_address, want.addr);
                if (res.data_value !== want.value)
                    report_mismatch("data_value", res.data_value, want.value);
            end
        end
    end

    initial begin : stimulus
        logic [7:0] station_set [NUM_SETTINGS];
        logic [7:0] count_set [NUM_SETTINGS];
        int         chars_start;
        int         frames_start;
        rst_n      <= 1'b0;
        rx.valid   <= 1'b0;
        rx.rx_byte <= '0;
        cfg.valid  <= 1'b0;
        cfg.index  <= '0;
        cfg.data   <= '0;
        station_set = '{8'h00, 8'hFF, 8'hA5, 8'($urandom), 8'($urandom), 8'h01};
        count_set   = '{8'h00, 8'hFF, 8'h01, 8'($urandom_range(1, 255)), 8'($urandom), 8'h05};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames run on the register values left by reset.
        for (int r = 0; r < NUM_ROWS; r++) begin
            row_check_now = directed_checks[r];
            for (int i = 0; i < directed_chars[r].len(); i++)
                send_char(directed_chars[r][i]);
        end
        row_check_now = BY_DECODER;

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            settle();
            steady = (p == NUM_SETTINGS - 1);
            program_config(station_set[p], count_set[p],
                           (p == 0) ? 8'hFF : 8'($urandom_range(2, 254)));
            chars_start  = chars_sent;
            frames_start = frames_announced;
            while (chars_sent - chars_start < PHASE_CHARS ||
                   frames_announced - frames_start < PHASE_FRAMES)
                send_random_frame();
        end
        settle();

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
